### src/cfr_pkg.sv
`default_nettype none

package cfr_pkg;

    localparam logic [7:0] HDR0        = 8'hAA;
    localparam logic [7:0] HDR1        = 8'hAF;
    localparam logic [7:0] HDR2        = 8'h05;
    localparam logic [7:0] FUNC_LIMIT  = 8'hF1;
    localparam logic [7:0] LEN_LIMIT   = 8'd50;
    localparam logic [7:0] FUNC_CMD    = 8'hE0;
    localparam logic [7:0] FUNC_PARAM  = 8'hE1;
    localparam logic [7:0] GROUP_CHECK = 8'hE1;
    localparam logic [5:0] PARAM_MIN_LEN = 6'd6;
    localparam logic [5:0] CMD_MIN_LEN   = 6'd3;
    localparam int unsigned HELD_SLOTS = 5;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_HDR2    = 3'd2,
        PH_FUNC    = 3'd3,
        PH_LEN     = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_CHECK   = 3'd6
    } phase_t;

    typedef struct packed {
        logic               frame_status;
        logic [7:0]         function_code;
        logic [5:0]         payload_length;
        logic               param_valid;
        logic [7:0]         param_index;
        logic signed [15:0] param_value;
        logic               command_valid;
        logic [7:0]         command_group;
        logic [7:0]         command_code;
        logic               check_request;
        logic               echo_request;
    } result_t;

    // Handshake between the top level and the parser.
    typedef struct packed {
        logic step;      // parser consumes the held byte this cycle
        logic produce;   // the held byte, once consumed, yields a result
    } step_ctl_t;

endpackage

`default_nettype wire

### src/cfr_in_if.sv
`default_nettype none

interface cfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/cfr_out_if.sv
`default_nettype none

interface cfr_out_if;
    logic               valid;
    logic               ready;
    logic               frame_status;
    logic [7:0]         function_code;
    logic [5:0]         payload_length;
    logic               param_valid;
    logic [7:0]         param_index;
    logic signed [15:0] param_value;
    logic               command_valid;
    logic [7:0]         command_group;
    logic [7:0]         command_code;
    logic               check_request;
    logic               echo_request;

    modport source (
        output valid, input ready,
        output frame_status, output function_code, output payload_length,
        output param_valid, output param_index, output param_value,
        output command_valid, output command_group, output command_code,
        output check_request, output echo_request
    );
    modport sink (
        input valid, output ready,
        input frame_status, input function_code, input payload_length,
        input param_valid, input param_index, input param_value,
        input command_valid, input command_group, input command_code,
        input check_request, input echo_request
    );
endinterface

`default_nettype wire

### src/cfr_parser.sv
`default_nettype none

module cfr_parser
    import cfr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire logic [7:0] rx_byte,
    output logic           produce,
    output result_t        result
);

    phase_t     phase_reg, phase_next;
    logic [5:0] remaining_reg, remaining_next;
    logic [5:0] index_reg, index_next;
    logic [5:0] length_reg, length_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] function_reg, function_next;
    logic [7:0] held_reg [HELD_SLOTS];
    logic       hold_en;
    logic [2:0] hold_slot;
    logic       sum_ok;

    // Next state of the frame parser.
    always_comb
    begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        index_next     = index_reg;
        length_next    = length_reg;
        sum_next       = sum_reg;
        function_next  = function_reg;
        if (step)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == HDR0)
                    begin
                        sum_next   = rx_byte;
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1:
                begin
                    if (rx_byte == HDR1)
                    begin
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_HDR2;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_HDR2:
                begin
                    if (rx_byte == HDR2)
                    begin
                        sum_next   = sum_reg + rx_byte;
                        phase_next = PH_FUNC;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_FUNC:
                begin
                    if (rx_byte < FUNC_LIMIT)
                    begin
                        function_next = rx_byte;
                        sum_next      = sum_reg + rx_byte;
                        phase_next    = PH_LEN;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_LEN:
                begin
                    if (rx_byte < LEN_LIMIT)
                    begin
                        length_next    = rx_byte[5:0];
                        remaining_next = rx_byte[5:0];
                        index_next     = '0;
                        sum_next       = sum_reg + rx_byte;
                        phase_next     = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_PAYLOAD:
                begin
                    if (remaining_reg != '0)
                    begin
                        index_next     = index_reg + 6'd1;
                        remaining_next = remaining_reg - 6'd1;
                        sum_next       = sum_reg + rx_byte;
                        if (remaining_reg == 6'd1)
                        begin
                            phase_next = PH_CHECK;
                        end
                    end
                    else
                    begin
                        // A zero-length frame is dropped here.
                        phase_next = PH_IDLE;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Only payload bytes 0, 1, 2, 4 and 5 are kept; byte 3 is not needed.
    always_comb
    begin
        hold_en   = step && (phase_reg == PH_PAYLOAD) && (remaining_reg != '0);
        hold_slot = '0;
        case (index_reg)
            6'd0: hold_slot = 3'd0;
            6'd1: hold_slot = 3'd1;
            6'd2: hold_slot = 3'd2;
            6'd4: hold_slot = 3'd3;
            6'd5: hold_slot = 3'd4;
            default: hold_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            remaining_reg <= '0;
            index_reg     <= '0;
            length_reg    <= '0;
            sum_reg       <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            index_reg     <= index_next;
            length_reg    <= length_next;
            sum_reg       <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        function_reg <= function_next;
        if (hold_en)
        begin
            held_reg[hold_slot] <= rx_byte;
        end
    end

    assign produce = (phase_reg == PH_CHECK);
    assign sum_ok  = (sum_reg == rx_byte);

    // Result for the checksum byte; fields without meaning stay zero.
    always_comb
    begin
        result                = '0;
        result.frame_status   = !sum_ok;
        result.function_code  = function_reg;
        result.payload_length = length_reg;
        if (sum_ok)
        begin
            if (function_reg == FUNC_PARAM)
            begin
                result.echo_request = 1'b1;
                if (length_reg >= PARAM_MIN_LEN)
                begin
                    result.param_valid = 1'b1;
                    result.param_index = held_reg[1];
                    result.param_value = {held_reg[3], held_reg[4]};
                end
            end
            else if (function_reg == FUNC_CMD)
            begin
                result.echo_request = 1'b1;
                if (length_reg >= CMD_MIN_LEN)
                begin
                    result.command_valid = 1'b1;
                    result.command_group = held_reg[0];
                    result.command_code  = held_reg[2];
                    result.check_request = (held_reg[0] == GROUP_CHECK);
                end
            end
        end
    end

endmodule

`default_nettype wire

### src/checksummed_command_frame_receiver.sv
// Receiver for checksummed command frames, one byte per transfer.
//
// The rx channel carries one received serial byte per transfer. A frame is
// the header AA AF 05, a function byte below F1, a length byte below decimal 50,
// that many payload bytes and a checksum equal to the 8-bit sum of all
// earlier frame bytes. Any byte that does not fit the frame returns the
// parser to idle, and frames of length zero are dropped silently.
// The frame channel carries one result transfer per checksum byte: the match
// status, function code and length and, when the checksum matched, the
// parameter fields of an E1 frame of at least 6 payload bytes or the command
// fields of an E0 frame of at least 3 payload bytes.
// The input register holds an accepted byte until the parser consumes it; a
// checksum byte loads its result into the result register as it is consumed.
// Throughput is one byte per cycle unless a checksum byte meets a full result
// register, set by the single input register in front of the parser.
// Reset returns the parser to idle and empties both the input register and
// the result register; no partial frame survives reset.
// When the frame sink stalls, the result waits in the result register. Bytes
// that yield no result keep flowing; a checksum byte waits in the input
// register until the result register frees, and rx ready then drops.

`default_nettype none

module checksummed_command_frame_receiver
    import cfr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    cfr_in_if.sink     rx,
    cfr_out_if.source  frame
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_data_reg;
    result_t    parse_result;
    step_ctl_t  ctl;
    logic       out_free;
    logic       produce;

    // The result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || frame.ready;
    assign ctl.produce = produce;
    assign ctl.step    = in_valid_reg && (!ctl.produce || out_free);
    assign rx.ready    = !in_valid_reg || ctl.step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.valid && rx.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (ctl.step)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    cfr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (ctl.step),
        .rx_byte (in_byte_reg),
        .produce (produce),
        .result  (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.step && ctl.produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (frame.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step && ctl.produce)
        begin
            out_data_reg <= parse_result;
        end
    end

    assign frame.valid          = out_valid_reg;
    assign frame.frame_status   = out_data_reg.frame_status;
    assign frame.function_code  = out_data_reg.function_code;
    assign frame.payload_length = out_data_reg.payload_length;
    assign frame.param_valid    = out_data_reg.param_valid;
    assign frame.param_index    = out_data_reg.param_index;
    assign frame.param_value    = out_data_reg.param_value;
    assign frame.command_valid  = out_data_reg.command_valid;
    assign frame.command_group  = out_data_reg.command_group;
    assign frame.command_code   = out_data_reg.command_code;
    assign frame.check_request  = out_data_reg.check_request;
    assign frame.echo_request   = out_data_reg.echo_request;

    // A byte held back by a full result register must not change.
    a_held_byte_stable: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !ctl.step |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held input byte changed while waiting");

    // A mismatched frame reports nothing beyond status, function and length.
    a_mismatch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.frame_status
        |-> !out_data_reg.param_valid && !out_data_reg.command_valid
            && !out_data_reg.echo_request)
        else $error("mismatched frame carries decoded fields");

    // Parameter and command decodes exclude each other.
    a_decode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_data_reg.param_valid && out_data_reg.command_valid))
        else $error("parameter and command both decoded");

    // A check request only comes with a decoded command.
    a_check_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.check_request |-> out_data_reg.command_valid)
        else $error("check request without command");

    // A new result is only loaded when the previous one has left.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step && ctl.produce |-> out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire
